>>> rtl/fkmt_pkg.sv
// ----------------------------------------------------------------------------
// fkmt_pkg
// Shared types, constants and the hash step function for the keyed memo table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fkmt_pkg;

  // The hash restarts from the FNV offset basis after each completed key.
  localparam logic [63:0] HASH_BASIS = 64'hcbf2_9ce4_8422_2325;
  // A get that misses reports the bit pattern of -1.0.
  localparam logic [63:0] MISS_VALUE = 64'hbff0_0000_0000_0000;

  // Operation carried with the last word of a key.
  typedef enum logic [1:0] {
    OP_GET    = 2'd0,
    OP_SET    = 2'd1,
    OP_DELETE = 2'd2,
    OP_NONE   = 2'd3
  } fkmt_op_t;

  // Status reported with each result.
  typedef enum logic [2:0] {
    ST_FOUND     = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_INSERTED  = 3'd2,
    ST_UPDATED   = 3'd3,
    ST_DELETED   = 3'd4,
    ST_FULL      = 3'd5
  } fkmt_status_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_COMMIT,
    S_RESULT
  } fkmt_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic hash_step;    // a key word was accepted
    logic scan_start;   // latch the key and restart the slot counter
    logic issue;        // read the slot at the counter
    logic clear_wr;     // invalidate the slot at the counter
    logic commit;       // update the table and build the result
    logic load_result;  // move the result into the output register
  } fkmt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cmp_hit;      // the slot being compared matches the key
    logic cmp_last;     // the slot being compared is the last one
    logic cnt_end;      // the counter sits on the last slot
    logic out_busy;     // the output register holds a result not yet taken
  } fkmt_stat_t;

  // One FNV-1a step: xor the word in, then multiply by the prime
  // 2^40 + 2^8 + 2^7 + 2^5 + 2^4 + 2^1 + 1 modulo 2^64, as a shift-add.
  function automatic logic [63:0] fnv_step(input logic [63:0] hash,
                                           input logic [63:0] word);
    logic [63:0] mix;
    mix = hash ^ word;
    return (mix << 40) + (mix << 8) + (mix << 7) + (mix << 5) +
           (mix << 4) + (mix << 1) + mix;
  endfunction

endpackage

`default_nettype wire

>>> rtl/fkmt_ctrl.sv
// ----------------------------------------------------------------------------
// fkmt_ctrl
// Sequencer: clears the table after reset, takes key words, runs the slot
// scan, commits the table update and hands the result to the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fkmt_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             command,
  input  logic                   key_last,
  input  fkmt_pkg::fkmt_stat_t   stat,
  output fkmt_pkg::fkmt_cmd_t    cmd
);
  import fkmt_pkg::*;

  fkmt_state_t state;
  fkmt_state_t state_next;
  logic        accept;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    accept     = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (stat.cnt_end) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        accept   = in_valid;
        if (accept) begin
          cmd.hash_step = 1'b1;
          if (key_last && fkmt_op_t'(command) != OP_NONE) begin
            cmd.scan_start = 1'b1;
            state_next     = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
        if (stat.cmp_hit || stat.cmp_last) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_RESULT;
      end
      S_RESULT: begin
        // Wait until the output register is free or being emptied.
        if (!stat.out_busy) begin
          cmd.load_result = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/fkmt_dp.sv
// ----------------------------------------------------------------------------
// fkmt_dp
// Datapath: running hash, slot counter, key and value memories, scan compare,
// table update and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fkmt_dp #(
  parameter int ENTRIES = 256
) (
  input  logic                   clk,
  input  logic                   rst,
  input  fkmt_pkg::fkmt_cmd_t    cmd,
  output fkmt_pkg::fkmt_stat_t   stat,
  input  logic [1:0]             command,
  input  logic [63:0]            key_word,
  input  logic                   key_last,
  input  logic [63:0]            store_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [2:0]             status,
  output logic [63:0]            read_value
);
  import fkmt_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [CW-1:0] CNT_LAST = CW'(ENTRIES - 1);
  localparam logic [CW-1:0] CNT_DONE = CW'(ENTRIES);
  localparam logic [IW-1:0] IDX_LAST = IW'(ENTRIES - 1);

  // Tag memory holds {valid, key}; value memory holds the stored pattern.
  logic [64:0] tag_mem [ENTRIES];
  logic [63:0] val_mem [ENTRIES];

  logic [63:0]  hash;
  logic [63:0]  hash_next;
  logic [63:0]  key_r;
  logic [63:0]  value_r;
  fkmt_op_t     op_r;
  logic [CW-1:0] cnt;
  logic         rd_en;
  logic [64:0]  tag_q;
  logic [63:0]  val_q;
  logic [IW-1:0] q_idx;
  logic         q_vld;
  logic         cmp_hit;
  logic         cmp_free;
  logic         match_found;
  logic [IW-1:0] match_idx;
  logic [63:0]  match_val;
  logic         free_found;
  logic [IW-1:0] free_idx;
  logic         tag_we;
  logic [IW-1:0] tag_wa;
  logic [64:0]  tag_wd;
  logic         val_we;
  logic [IW-1:0] val_wa;
  fkmt_status_t res_status;
  fkmt_status_t res_status_next;
  logic [63:0]  res_value;
  logic [63:0]  res_value_next;

  assign hash_next = fnv_step(hash, key_word);

  // Running hash; it returns to the basis after every last word.
  always_ff @(posedge clk) begin
    if (rst) begin
      hash <= HASH_BASIS;
    end else if (cmd.hash_step) begin
      hash <= key_last ? HASH_BASIS : hash_next;
    end
  end

  // Request latch for the command that runs against the table.
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      key_r   <= hash_next;
      value_r <= store_value;
      op_r    <= fkmt_op_t'(command);
    end
  end

  // Slot counter, shared by the clearing pass and the scan.
  assign rd_en = cmd.issue && (cnt != CNT_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.scan_start) begin
      cnt <= '0;
    end else if (cmd.clear_wr || rd_en) begin
      cnt <= cnt + CW'(1);
    end
  end

  // Memory write port selection.
  always_comb begin
    tag_we = 1'b0;
    tag_wa = cnt[IW-1:0];
    tag_wd = '0;
    val_we = 1'b0;
    val_wa = match_found ? match_idx : free_idx;
    if (cmd.clear_wr) begin
      tag_we = 1'b1;
    end else if (cmd.commit) begin
      if (op_r == OP_SET && !match_found && free_found) begin
        tag_we = 1'b1;
        tag_wa = free_idx;
        tag_wd = {1'b1, key_r};
      end else if (op_r == OP_DELETE && match_found) begin
        tag_we = 1'b1;
        tag_wa = match_idx;
        tag_wd = {1'b0, key_r};
      end
      val_we = (op_r == OP_SET) && (match_found || free_found);
    end
  end

  // Tag and value memories with registered reads.
  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[tag_wa] <= tag_wd;
    end
    if (rd_en) begin
      tag_q <= tag_mem[cnt[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[val_wa] <= value_r;
    end
    if (rd_en) begin
      val_q <= val_mem[cnt[IW-1:0]];
    end
  end

  // Read pipeline tracking: which slot the registered data belongs to.
  always_ff @(posedge clk) begin
    if (rst) begin
      q_vld <= 1'b0;
    end else begin
      q_vld <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      q_idx <= cnt[IW-1:0];
    end
  end

  // Compare the slot just read against the key.
  assign cmp_hit  = q_vld && tag_q[64] && (tag_q[63:0] == key_r);
  assign cmp_free = q_vld && !tag_q[64];

  // Keep the lowest matching slot and the lowest free slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      match_found <= 1'b0;
      free_found  <= 1'b0;
    end else if (cmd.scan_start) begin
      match_found <= 1'b0;
      free_found  <= 1'b0;
    end else begin
      if (cmp_hit && !match_found) begin
        match_found <= 1'b1;
      end
      if (cmp_free && !free_found) begin
        free_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_hit && !match_found) begin
      match_idx <= q_idx;
      match_val <= val_q;
    end
    if (cmp_free && !free_found) begin
      free_idx <= q_idx;
    end
  end

  // Result of the command, built while the table is updated.
  always_comb begin
    res_status_next = ST_NOT_FOUND;
    res_value_next  = MISS_VALUE;
    unique case (op_r)
      OP_GET: begin
        if (match_found) begin
          res_status_next = ST_FOUND;
          res_value_next  = match_val;
        end
      end
      OP_SET: begin
        if (match_found) begin
          res_status_next = ST_UPDATED;
        end else if (free_found) begin
          res_status_next = ST_INSERTED;
        end else begin
          res_status_next = ST_FULL;
        end
      end
      OP_DELETE: begin
        if (match_found) begin
          res_status_next = ST_DELETED;
        end
      end
      default: begin
        res_status_next = ST_NOT_FOUND;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_status <= res_status_next;
      res_value  <= res_value_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      status     <= 3'(res_status);
      read_value <= res_value;
    end
  end

  // Status back to the controller.
  always_comb begin
    stat.cmp_hit  = cmp_hit;
    stat.cmp_last = q_vld && (q_idx == IDX_LAST);
    stat.cnt_end  = (cnt == CNT_LAST);
    stat.out_busy = out_valid && !out_ready;
  end

endmodule

`default_nettype wire

>>> rtl/fnv_keyed_memo_table.sv
// ----------------------------------------------------------------------------
// fnv_keyed_memo_table
// Memo table keyed by a 64-bit FNV-1a hash of a stream of key words.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests (in_valid/in_ready) carry one key word each, with command,
//   key_last and store_value. Every word is folded into the running hash
//   as it is accepted. On the word marked key_last the command (get, set,
//   delete) runs against the table and produces one output request (status,
//   read_value); command code 3 only restarts the hash and gives no result.
//   A last word starts a scan of the key memory, one slot read per cycle
//   through its single read port, stopping at the first match or after the
//   last slot. A commit step then updates the table and builds the result,
//   which is loaded into the output register. in_ready is low from the last
//   word until the result is loaded.
//   A result waiting in the output register does not block new key words;
//   only a following key's result waits if the receiver keeps out_ready low.
//   Reset: the hash returns to the offset basis and a clearing pass
//   invalidates all ENTRIES slots, one per cycle, during which in_ready
//   is low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fnv_keyed_memo_table #(
  parameter int ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [63:0] key_word,
  input  logic        key_last,
  input  logic [63:0] store_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [63:0] read_value
);
  import fkmt_pkg::*;

  fkmt_cmd_t  cmd;
  fkmt_stat_t stat;

  // Sequencer.
  fkmt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .command  (command),
    .key_last (key_last),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Hash, table and output register.
  fkmt_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .command     (command),
    .key_word    (key_word),
    .key_last    (key_last),
    .store_value (store_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .read_value  (read_value)
  );

  // A table command starts only from an accepted last word.
  assert property (@(posedge clk) disable iff (rst)
    cmd.scan_start |-> (in_valid && in_ready && key_last))
    else $error("scan started without an accepted last word");

  // A new result appears only after the controller loaded it.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.load_result))
    else $error("output became valid without a load");

  // Only a get hit carries a stored value; every other result reads -1.0.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != 3'(ST_FOUND)) |-> (read_value == MISS_VALUE))
    else $error("non-hit result carries a stored value");

  // Input is never taken while the table is being scanned or updated.
  assert property (@(posedge clk) disable iff (rst)
    (cmd.issue || cmd.commit || cmd.clear_wr) |-> !in_ready)
    else $error("input accepted during a table operation");

endmodule

`default_nettype wire

>>> dv/tb_fnv_keyed_memo_table.sv
// ----------------------------------------------------------------------------
// tb_fnv_keyed_memo_table
// Self-checking testbench for the hash-keyed memo table. A directed stimulus
// table covers the special cases: misses, inserts, updates, deletes, aliased
// hashes, the unused command and short keys. Random keys from a small pool
// follow, mixed with noise and broken keys, and then a pass fills the table
// until it is full. Each result is checked against a typed expectation or
// a local model of the hash and table. Both sides idle at random, and the
// receiver holds off once for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_fnv_keyed_memo_table;

  import fkmt_pkg::*;

  localparam int TBL_SLOTS = 256;
  localparam logic [63:0] FNV_PRIME = 64'h0000_0100_0000_01b3;
  localparam logic [63:0] ALL_ONES = 64'hffff_ffff_ffff_ffff;
  localparam logic [63:0] TWIN_HEAD = 64'h0000_1234_5678_9abc;
  // Five-word key: four index words and one element; word 0 is the rightmost.
  localparam logic [4:0][63:0] LONG_KEY = {64'h0123_4567_89ab_cdef,
                                           64'h7fff_ffff_ffff_ffff,
                                           64'h8000_0000_0000_0000,
                                           64'h0000_0000_0000_0001,
                                           64'h0000_0000_0000_0000};
  localparam int POOL_KEYS = 20;
  localparam int MAX_KEY_WORDS = 7;
  localparam int RANDOM_ITEMS = 300;
  localparam int PRESSURE_AT = 30;
  localparam int PRESSURE_CYCLES = 600;
  localparam int DRAIN_LIMIT = 8 * TBL_SLOTS + 1000;
  localparam longint RUN_LIMIT_NS = 64'd8_000_000;

  typedef struct packed {
    fkmt_status_t st;
    logic [63:0]  rd;
  } memo_result_t;

  typedef struct packed {
    fkmt_op_t     op;
    logic [63:0]  word;
    logic         last;
    logic [63:0]  value;
    logic         typed;
    memo_result_t res;
  } memo_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  command;
  logic [63:0] key_word;
  logic        key_last;
  logic [63:0] store_value;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  status;
  logic [63:0] read_value;

  // Local copy of the hash and of the table.
  logic [63:0] memo_hash;
  logic [63:0] memo_key [TBL_SLOTS];
  logic [63:0] memo_val [TBL_SLOTS];
  bit          memo_live [TBL_SLOTS];
  int          memo_used;

  memo_result_t pending_results[$];
  memo_row_t    dir_rows[$];
  int           words_sent;
  int           results_seen;
  int           fail_count;
  bit           sender_calm;
  bit           sink_calm;

  fnv_keyed_memo_table #(.ENTRIES(TBL_SLOTS)) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .command(command),
    .key_word(key_word),
    .key_last(key_last),
    .store_value(store_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .read_value(read_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Fold one key word into the hash; on the last word run the command
  // against the table. Returns 1 when the word produces a result.
  function automatic bit memo_predict(input fkmt_op_t op, input logic [63:0] word,
                                      input bit last, input logic [63:0] value,
                                      output memo_result_t res);
    logic [63:0] key;
    int hit;
    int hole;
    res.st = ST_NOT_FOUND;
    res.rd = MISS_VALUE;
    memo_hash = (memo_hash ^ word) * FNV_PRIME;
    if (!last) return 1'b0;
    key = memo_hash;
    memo_hash = HASH_BASIS;
    if (op == OP_NONE) return 1'b0;
    // Lowest matching slot and lowest free slot.
    hit = -1;
    hole = -1;
    for (int i = TBL_SLOTS - 1; i >= 0; i--) begin
      if (memo_live[i] && memo_key[i] == key) hit = i;
      if (!memo_live[i]) hole = i;
    end
    case (op)
      OP_GET: begin
        if (hit >= 0) begin
          res.st = ST_FOUND;
          res.rd = memo_val[hit];
        end
      end
      OP_SET: begin
        if (hit >= 0) begin
          memo_val[hit] = value;
          res.st = ST_UPDATED;
        end else if (hole >= 0) begin
          memo_key[hole] = key;
          memo_val[hole] = value;
          memo_live[hole] = 1'b1;
          memo_used++;
          res.st = ST_INSERTED;
        end else begin
          res.st = ST_FULL;
        end
      end
      default: begin
        if (hit >= 0) begin
          memo_live[hit] = 1'b0;
          memo_used--;
          res.st = ST_DELETED;
        end
      end
    endcase
    return 1'b1;
  endfunction

  function automatic void log_failure(string what);
    fail_count++;
    if (fail_count <= 10) $display("mismatch: %s", what);
  endfunction

  // Idle draws; each side switches now and then into a stretch without gaps.
  function automatic int sender_pause();
    if ($urandom_range(0, 39) == 0) sender_calm = !sender_calm;
    return sender_calm ? 0 : int'($urandom_range(0, 17));
  endfunction

  function automatic int sink_pause();
    if ($urandom_range(0, 29) == 0) sink_calm = !sink_calm;
    return sink_calm ? 0 : int'($urandom_range(0, 17));
  endfunction

  function automatic void add_row(fkmt_op_t op, logic [63:0] word, bit last,
                                  logic [63:0] value, bit typed, fkmt_status_t st,
                                  logic [63:0] rd);
    memo_row_t row;
    row.op = op;
    row.word = word;
    row.last = last;
    row.value = value;
    row.typed = typed;
    row.res.st = st;
    row.res.rd = rd;
    dir_rows.push_back(row);
  endfunction

  // Offer one key word as a request and record what it should produce.
  // A typed expectation replaces the local prediction for that word.
  task automatic drive_word(input fkmt_op_t op, input logic [63:0] word, input bit last,
                            input logic [63:0] value, input bit typed,
                            input memo_result_t typed_res);
    int pause;
    bit got;
    memo_result_t pred;
    pause = sender_pause();
    if (pause > 0) begin
      in_valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= op;
    key_word <= word;
    key_last <= last;
    store_value <= value;
    do @(posedge clk); while (in_ready !== 1'b1);
    words_sent++;
    got = memo_predict(op, word, last, value, pred);
    if (typed) pending_results.push_back(typed_res);
    else if (got) pending_results.push_back(pred);
  endtask

  // Result side: random stalls, one long hold-off, and the check of each result.
  initial begin : result_sink
    int pause;
    memo_result_t want;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      pause = sink_pause();
      if (results_seen == PRESSURE_AT) pause = PRESSURE_CYCLES;
      if (pause > 0) begin
        out_ready <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      results_seen++;
      if (pending_results.size() == 0) begin
        log_failure($sformatf("result with no request pending: status %0d read_value %h",
                              status, read_value));
      end else begin
        want = pending_results.pop_front();
        if (status !== want.st || read_value !== want.rd)
          log_failure($sformatf("result %0d: status %0d (want %0d), read_value %h (want %h)",
                                results_seen, status, want.st, read_value, want.rd));
      end
    end
  end

  initial begin : stimulus
    logic [63:0] twin_tail;
    logic [63:0] pool_words [POOL_KEYS][MAX_KEY_WORDS];
    int          pool_len [POOL_KEYS];
    logic [63:0] word;
    logic [63:0] fill_word;
    fkmt_op_t    op;
    int          key_len;
    int          pick;
    int          k;
    int          guard;
    int          waited;

    rst <= 1'b1;
    in_valid <= 1'b0;
    command <= OP_GET;
    key_word <= '0;
    key_last <= 1'b0;
    store_value <= '0;
    memo_hash = HASH_BASIS;
    memo_used = 0;
    for (int i = 0; i < TBL_SLOTS; i++) memo_live[i] = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed table. A two-word key whose hash equals that of the one-word
    // key of all ones lets the aliasing of colliding hashes be checked.
    twin_tail = (HASH_BASIS ^ TWIN_HEAD) * FNV_PRIME;
    twin_tail = twin_tail ^ HASH_BASIS ^ ALL_ONES;
    add_row(OP_GET, 64'h0, 1'b1, 64'h0, 1'b1, ST_NOT_FOUND, MISS_VALUE);
    add_row(OP_DELETE, ALL_ONES, 1'b1, 64'h0, 1'b1, ST_NOT_FOUND, MISS_VALUE);
    add_row(OP_SET, ALL_ONES, 1'b1, 64'h0, 1'b1, ST_INSERTED, MISS_VALUE);
    add_row(OP_SET, ALL_ONES, 1'b1, ALL_ONES, 1'b1, ST_UPDATED, MISS_VALUE);
    add_row(OP_GET, ALL_ONES, 1'b1, 64'h0, 1'b1, ST_FOUND, ALL_ONES);
    for (int i = 0; i < 5; i++)
      add_row(i == 4 ? OP_SET : fkmt_op_t'(i % 4), LONG_KEY[i], i == 4,
              64'h8000_0000_0000_0001, i == 4, ST_INSERTED, MISS_VALUE);
    for (int i = 0; i < 5; i++)
      add_row(i == 4 ? OP_GET : OP_SET, LONG_KEY[i], i == 4, ALL_ONES, i == 4,
              ST_FOUND, 64'h8000_0000_0000_0001);
    add_row(OP_SET, TWIN_HEAD, 1'b0, 64'h0, 1'b0, ST_FOUND, 64'h0);
    add_row(OP_GET, twin_tail, 1'b1, 64'h0, 1'b1, ST_FOUND, ALL_ONES);
    // The unused command ends a key without a result but still restarts the hash.
    add_row(OP_GET, 64'h5555_5555_5555_5555, 1'b0, 64'h0, 1'b0, ST_FOUND, 64'h0);
    add_row(OP_NONE, 64'haaaa_aaaa_aaaa_aaaa, 1'b1, 64'h0, 1'b0, ST_FOUND, 64'h0);
    add_row(OP_GET, ALL_ONES, 1'b1, 64'h0, 1'b1, ST_FOUND, ALL_ONES);
    add_row(OP_DELETE, ALL_ONES, 1'b1, 64'h0, 1'b1, ST_DELETED, MISS_VALUE);
    add_row(OP_GET, ALL_ONES, 1'b1, 64'h0, 1'b1, ST_NOT_FOUND, MISS_VALUE);
    foreach (dir_rows[i])
      drive_word(dir_rows[i].op, dir_rows[i].word, dir_rows[i].last, dir_rows[i].value,
                 dir_rows[i].typed, dir_rows[i].res);

    // Pool of keys: mostly four indices plus elements, some short ones.
    for (int p = 0; p < POOL_KEYS; p++) begin
      pool_len[p] = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 3))
                                                : int'($urandom_range(5, MAX_KEY_WORDS));
      for (int i = 0; i < MAX_KEY_WORDS; i++)
        pool_words[p][i] = (p % 2 == 1 && i < 4) ? 64'($urandom_range(0, 63))
                                                 : {$urandom, $urandom};
    end

    // Random keys: mostly whole pool keys, then broken pool keys and noise.
    words_sent = 0;
    while (words_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      k = $urandom_range(0, POOL_KEYS - 1);
      key_len = pool_len[k];
      if (pick >= 85) key_len = $urandom_range(1, MAX_KEY_WORDS);
      pick = (pick < 92) ? 0 : 1;
      k = (pick == 0) ? k : k;
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7: op = OP_GET;
        8, 9, 10, 11, 12, 13, 14: op = OP_SET;
        15, 16, 17, 18: op = OP_DELETE;
        default: op = OP_NONE;
      endcase
      for (int i = 0; i < key_len; i++) begin
        word = (pick == 0 && i < pool_len[k]) ? pool_words[k][i] : {$urandom, $urandom};
        drive_word(i == key_len - 1 ? op : fkmt_op_t'($urandom_range(0, 3)), word,
                   i == key_len - 1, {$urandom, $urandom}, 1'b0, '0);
      end
    end

    // Fill every slot with one-word keys, then run into the full table.
    guard = 0;
    fill_word = '0;
    while (memo_used < TBL_SLOTS && guard < 2 * TBL_SLOTS) begin
      fill_word = {$urandom, $urandom};
      drive_word(OP_SET, fill_word, 1'b1, {$urandom, $urandom}, 1'b0, '0);
      guard++;
    end
    repeat (2) drive_word(OP_SET, {$urandom, $urandom}, 1'b1, {$urandom, $urandom}, 1'b0, '0);
    drive_word(OP_GET, fill_word, 1'b1, {$urandom, $urandom}, 1'b0, '0);
    drive_word(OP_DELETE, fill_word, 1'b1, {$urandom, $urandom}, 1'b0, '0);
    // The freed slot is taken again, and then the table is full once more.
    repeat (2) drive_word(OP_SET, {$urandom, $urandom}, 1'b1, {$urandom, $urandom}, 1'b0, '0);
    in_valid <= 1'b0;

    // Drain the outstanding results, then watch for anything extra.
    waited = 0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_results.size() != 0) begin
      log_failure($sformatf("%0d expected results never arrived", pending_results.size()));
      pending_results.delete();
    end
    repeat (TBL_SLOTS + 8) @(posedge clk);

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("== FAIL ==");
    $finish;
  end

endmodule
